// ----- rtl/sfl_pkg.sv -----
// sfl_pkg: shared constants, function codes and the segment descriptor type
// for the segmented function lookup block. No dependencies.
package sfl_pkg;

	// sizing
	localparam int MAX_SEGMENTS = 16;
	localparam int STORE_DEPTH  = 1024;
	localparam int KEY_WIDTH    = 32;

	localparam int SEG_W   = $clog2(MAX_SEGMENTS);      // descriptor index
	localparam int CNT_W   = 5;                         // segment_count register
	localparam int LR_W    = SEG_W + 2;                 // signed search bounds
	localparam int ADDR_W  = $clog2(STORE_DEPTH);       // sample store index
	localparam int SLOT_W  = 10;                        // slot / base field width
	localparam int DATA_W  = 32;                        // sample word width
	localparam int FIELD_W = 32;                        // key/wall/step port width
	localparam int DCNT_W  = $clog2(KEY_WIDTH + 1);     // divider step counter

	// function codes
	typedef enum logic [1:0] {
		F_DESC   = 2'd0,
		F_SAMPLE = 2'd1,
		F_LOOKUP = 2'd2,
		F_NONE   = 2'd3
	} func_t;

	// one segment descriptor as stored
	typedef struct packed {
		logic [KEY_WIDTH-1:0] lo;
		logic [KEY_WIDTH-1:0] hi;
		logic [KEY_WIDTH-1:0] step;
		logic [SLOT_W-1:0]    base;
	} desc_t;

endpackage

// ----- rtl/segmented_function_lookup.sv -----
// segmented_function_lookup: descriptor and sample memories, binary search
// sequencer, bit-serial divider and output register. Depends on sfl_pkg.
// Lookup steps: binary search probes of the descriptor table (at most 5 probes over 16
// segments), the bit-serial divide, the sample read, then the output register. Early
// misses and zero steps skip the divider.
// Throughput: one lookup at a time; input stalls until the result enters the output
// register.
// Reset: control and segment_count (to 1) clear at once; memories keep contents,
// no clearing pass.
module segmented_function_lookup
	import sfl_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [CNT_W-1:0]          cfg_wdata,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                func,
	input  logic [SLOT_W-1:0]         slot,
	input  logic [FIELD_W-1:0]        seg_start,
	input  logic [FIELD_W-1:0]        seg_end,
	input  logic [FIELD_W-1:0]        seg_step,
	input  logic [SLOT_W-1:0]         seg_base,
	input  logic signed [DATA_W-1:0]  sample_value,
	input  logic [FIELD_W-1:0]        key,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  value,
	output logic                      found
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PROBE = 7'b0000010,
		S_CMP   = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_ADDR  = 7'b0010000,
		S_READ  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]          count_q;
	logic [KEY_WIDTH-1:0]      key_q;
	logic signed [LR_W-1:0]    left_q;
	logic signed [LR_W-1:0]    right_q;
	logic [SEG_W-1:0]          mid_q;
	logic [SLOT_W-1:0]         base_q;

	// divider
	logic [KEY_WIDTH-1:0]      rem_q;
	logic [KEY_WIDTH-1:0]      quo_q;
	logic [KEY_WIDTH-1:0]      dvs_q;
	logic [DCNT_W-1:0]         dcnt_q;

	// result hold and output register
	logic signed [DATA_W-1:0]  res_value_q;
	logic                      res_found_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  value_q;
	logic                      found_q;

	// memories
	desc_t                     desc_mem [MAX_SEGMENTS];
	desc_t                     desc_rd_q;
	logic [DATA_W-1:0]         smp_mem [STORE_DEPTH];
	logic [DATA_W-1:0]         smp_rd_q;

	// combinational
	logic                      in_acc;
	logic                      desc_we;
	logic                      smp_we;
	desc_t                     desc_wr;
	logic [CNT_W-1:0]          count_eff;
	logic signed [LR_W-1:0]    mid;
	logic                      covered;
	logic [KEY_WIDTH:0]        rem_sh;
	logic [KEY_WIDTH:0]        trial;
	logic [KEY_WIDTH:0]        addr_sum;
	logic                      addr_ok;
	logic                      out_load;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// write decode; writes land only in idle, so no read of the same entry overlaps
	assign desc_we = in_acc && (func == F_DESC) && (32'(slot) < 32'(MAX_SEGMENTS));
	assign smp_we  = in_acc && (func == F_SAMPLE) && (32'(slot) < 32'(STORE_DEPTH));

	always_comb begin
		desc_wr.lo   = seg_start[KEY_WIDTH-1:0];
		desc_wr.hi   = seg_end[KEY_WIDTH-1:0];
		desc_wr.step = seg_step[KEY_WIDTH-1:0];
		desc_wr.base = seg_base;
	end

	// clamp the searched count
	assign count_eff = (32'(count_q) > 32'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : count_q;

	// midpoint: right >= left here, so the halving is a plain shift
	assign mid = left_q + ((right_q - left_q) >>> 1);

	assign covered = (desc_rd_q.lo <= key_q) && (desc_rd_q.hi >= key_q);

	// restoring divider step
	assign rem_sh = {rem_q, quo_q[KEY_WIDTH-1]};
	assign trial  = rem_sh - {1'b0, dvs_q};

	// sample address and range check
	assign addr_sum = {1'b0, quo_q} + (KEY_WIDTH+1)'(base_q);
	assign addr_ok  = (quo_q < KEY_WIDTH'(STORE_DEPTH))
		&& (addr_sum < (KEY_WIDTH+1)'(STORE_DEPTH));

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// descriptor memory
	always_ff @(posedge clk) begin
		if (desc_we) begin
			desc_mem[slot[SEG_W-1:0]] <= desc_wr;
		end
		if (state_q == S_PROBE) begin
			desc_rd_q <= desc_mem[mid[SEG_W-1:0]];
		end
	end

	// sample memory
	always_ff @(posedge clk) begin
		if (smp_we) begin
			smp_mem[slot[ADDR_W-1:0]] <= sample_value;
		end
		if (state_q == S_ADDR) begin
			smp_rd_q <= smp_mem[addr_sum[ADDR_W-1:0]];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// search and divide sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dcnt_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && (func == F_LOOKUP)) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (left_q > right_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (!covered) begin
						state_q <= S_PROBE;
					end else if (desc_rd_q.step == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
						dcnt_q  <= DCNT_W'(KEY_WIDTH);
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == DCNT_W'(1)) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					state_q <= addr_ok ? S_READ : S_DONE;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q       <= key[KEY_WIDTH-1:0];
				left_q      <= '0;
				right_q     <= LR_W'(count_eff) - LR_W'(1);
				res_value_q <= '0;
				res_found_q <= 1'b0;
			end
			S_PROBE: begin
				mid_q <= mid[SEG_W-1:0];
			end
			S_CMP: begin
				if (!covered) begin
					if (key_q > desc_rd_q.hi) begin
						left_q <= LR_W'(mid_q) + LR_W'(1);
					end else begin
						right_q <= LR_W'(mid_q) - LR_W'(1);
					end
				end
				rem_q  <= '0;
				quo_q  <= key_q - desc_rd_q.lo;
				dvs_q  <= desc_rd_q.step;
				base_q <= desc_rd_q.base;
			end
			S_DIV: begin
				// remainder stays below the divisor, so it fits the low bits
				if (!trial[KEY_WIDTH]) begin
					rem_q <= trial[KEY_WIDTH-1:0];
					quo_q <= {quo_q[KEY_WIDTH-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[KEY_WIDTH-1:0];
					quo_q <= {quo_q[KEY_WIDTH-2:0], 1'b0};
				end
			end
			S_READ: begin
				res_value_q <= smp_rd_q;
				res_found_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// output register: one result beat waits here while the block moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= res_value_q;
			found_q <= res_found_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign found     = found_q;

	// checks
	a_lookup_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (func == F_LOOKUP)) |=> (state_q == S_PROBE))
		else $error("lookup beat did not start the search");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (value == '0))
		else $error("not-found result carries a nonzero value");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ((dcnt_q != '0) && (32'(dcnt_q) <= 32'(KEY_WIDTH))))
		else $error("divider step count out of range");

	a_cmp_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ((LR_W'(mid_q) >= left_q) && (LR_W'(mid_q) <= right_q)))
		else $error("probe index outside search range");

endmodule

// ----- test/segmented_function_lookup_tb.sv -----
// segmented_function_lookup_tb: self-checking bench for the segmented function lookup block.
// It loads segment tables and samples, runs lookups and checks every result against its own predictor.
// Depends on sfl_pkg and the segmented_function_lookup RTL.
module segmented_function_lookup_tb;
	import sfl_pkg::*;

	localparam int SETTLE_CYCLES  = 64;     // covers the worst lookup latency
	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no beat on any port
	localparam int PHASES         = 12;

	// one request beat as queued for the driver
	typedef struct packed {
		func_t                func;
		logic [SLOT_W-1:0]    slot;
		logic [FIELD_W-1:0]   seg_start;
		logic [FIELD_W-1:0]   seg_end;
		logic [FIELD_W-1:0]   seg_step;
		logic [SLOT_W-1:0]    seg_base;
		logic [DATA_W-1:0]    sample_value;
		logic [FIELD_W-1:0]   key;
		logic                 drain_first;  // hold until all lookups have answered
	} request_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              found;
	} lookup_result_t;

	typedef desc_t [MAX_SEGMENTS-1:0] seg_table_t;

	// DUT ports
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CNT_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               func = '0;
	logic [SLOT_W-1:0]        slot = '0;
	logic [FIELD_W-1:0]       seg_start = '0;
	logic [FIELD_W-1:0]       seg_end = '0;
	logic [FIELD_W-1:0]       seg_step = '0;
	logic [SLOT_W-1:0]        seg_base = '0;
	logic signed [DATA_W-1:0] sample_value = '0;
	logic [FIELD_W-1:0]       key = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] value;
	logic                     found;

	// predictor state, updated as beats are accepted
	seg_table_t               model_segs;
	logic [DATA_W-1:0]        stored_samples [STORE_DEPTH];
	logic [CNT_W-1:0]         seg_count = CNT_W'(1);

	// stimulus planning state, updated as beats are queued
	seg_table_t               planned_segs;
	bit                       sample_written [STORE_DEPTH];

	request_t                 pending_requests [$];
	lookup_result_t           awaited_lookups [$];
	request_t                 cur_req;
	lookup_result_t           result_want;
	logic                     drive_next;

	int send_wait = 0, send_calm = 0, recv_wait = 0, recv_calm = 0;
	int idle_cycles = 0;
	int fail_count = 0, beats_in = 0, lookups_checked = 0, lookups_found = 0;
	int settings_written = 0;

	segmented_function_lookup DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.slot         (slot),
		.seg_start    (seg_start),
		.seg_end      (seg_end),
		.seg_step     (seg_step),
		.seg_base     (seg_base),
		.sample_value (sample_value),
		.key          (key),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.found        (found)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Binary search over the first segments, then the in-segment index.
	// Returns the sample address, or -1 when the lookup is not found.
	function automatic int locate_sample(seg_table_t tbl, logic [CNT_W-1:0] cnt,
			logic [KEY_WIDTH-1:0] k);
		int left, right, mid, hit;
		desc_t d;
		logic [KEY_WIDTH-1:0] idx;
		int addr;
		left = 0;
		right = ((int'(cnt) > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(cnt)) - 1;
		hit = -1;
		while (left <= right && hit < 0) begin
			mid = left + (right - left) / 2;
			d = tbl[mid];
			if (d.lo <= k && d.hi >= k)
				hit = mid;
			else if (k > d.hi)
				left = mid + 1;
			else
				right = mid - 1;
		end
		if (hit < 0)
			return -1;
		d = tbl[hit];
		if (d.step == '0)
			return -1;
		idx = (k - d.lo) / d.step;
		if (idx >= STORE_DEPTH)
			return -1;
		addr = int'(d.base) + int'(idx);
		if (addr >= STORE_DEPTH)
			return -1;
		return addr;
	endfunction

	// Update the tables for an accepted beat; a lookup adds its expected result.
	function automatic void apply_request(request_t r);
		desc_t d;
		int addr;
		lookup_result_t want;
		case (r.func)
			F_DESC: begin
				if (r.slot < MAX_SEGMENTS) begin
					d.lo = r.seg_start;
					d.hi = r.seg_end;
					d.step = r.seg_step;
					d.base = r.seg_base;
					model_segs[r.slot[SEG_W-1:0]] = d;
				end
			end
			F_SAMPLE: begin
				if (r.slot < STORE_DEPTH)
					stored_samples[r.slot] = r.sample_value;
			end
			F_LOOKUP: begin
				addr = locate_sample(model_segs, seg_count, r.key);
				if (addr >= 0) begin
					want.value = stored_samples[addr];
					want.found = 1'b1;
				end else begin
					want.value = '0;
					want.found = 1'b0;
				end
				awaited_lookups.insert(awaited_lookups.size(), want);
			end
			default: ;
		endcase
	endfunction

	// Wait before the next beat, drawn at random, with runs of back-to-back beats.
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic request_t random_request(func_t f);
		request_t r;
		r.func = f;
		r.slot = SLOT_W'($urandom);
		r.seg_start = $urandom;
		r.seg_end = $urandom;
		r.seg_step = $urandom;
		r.seg_base = SLOT_W'($urandom);
		r.sample_value = $urandom;
		r.key = $urandom;
		r.drain_first = ($urandom_range(0, 99) == 0);
		return r;
	endfunction

	// Queue one beat. A lookup that would land on a never-written sample gets
	// a sample write queued ahead of it.
	task automatic plan_request(request_t r);
		desc_t d;
		request_t fill;
		int addr;
		case (r.func)
			F_DESC: begin
				if (r.slot < MAX_SEGMENTS) begin
					d.lo = r.seg_start;
					d.hi = r.seg_end;
					d.step = r.seg_step;
					d.base = r.seg_base;
					planned_segs[r.slot[SEG_W-1:0]] = d;
				end
			end
			F_SAMPLE: sample_written[r.slot] = 1'b1;
			F_LOOKUP: begin
				addr = locate_sample(planned_segs, seg_count, r.key);
				if (addr >= 0 && !sample_written[addr]) begin
					fill = random_request(F_SAMPLE);
					fill.slot = SLOT_W'(addr);
					fill.drain_first = 1'b0;
					sample_written[addr] = 1'b1;
					pending_requests.insert(pending_requests.size(), fill);
				end
			end
			default: ;
		endcase
		pending_requests.insert(pending_requests.size(), r);
	endtask

	task automatic queue_desc(int idx, logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
			logic [FIELD_W-1:0] step, int base);
		request_t r;
		r = random_request(F_DESC);
		r.slot = SLOT_W'(idx);
		r.seg_start = lo;
		r.seg_end = hi;
		r.seg_step = step;
		r.seg_base = SLOT_W'(base);
		plan_request(r);
	endtask

	task automatic queue_sample(int addr, logic [DATA_W-1:0] v);
		request_t r;
		r = random_request(F_SAMPLE);
		r.slot = SLOT_W'(addr);
		r.sample_value = v;
		plan_request(r);
	endtask

	task automatic queue_lookup(logic [FIELD_W-1:0] k, bit drain);
		request_t r;
		r = random_request(F_LOOKUP);
		r.key = k;
		r.drain_first = r.drain_first | drain;
		plan_request(r);
	endtask

	// Sorted, non-overlapping segments 0..n-1 at a random scale
	task automatic queue_table(int n);
		logic [FIELD_W-1:0] cursor, width, lo, hi, step;
		int e, pick;
		e = $urandom_range(6, 26);
		cursor = ($urandom_range(0, 3) == 0) ? '0 : FIELD_W'($urandom_range(0, 1 << e));
		for (int i = 0; i < n; i++) begin
			width = ($urandom_range(0, 7) == 0) ? '0 : FIELD_W'($urandom_range(1, 1 << e));
			lo = cursor;
			hi = cursor + width;
			if (i == n - 1 && $urandom_range(0, 3) == 0)
				hi = '1;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				step = '0;
			else if (pick == 1)
				step = FIELD_W'(1);
			else
				step = ((hi - lo) >> $urandom_range(0, 5)) + 1;
			queue_desc(i, lo, hi, step, $urandom_range(0, STORE_DEPTH - 1));
			cursor = hi + 1 + FIELD_W'($urandom_range(0, 1 << e));
		end
	endtask

	// Walls, empty step, out-of-range addresses and ignored beats at reset count
	task automatic queue_directed();
		request_t r;
		queue_desc(0, 32'h0001_0000, 32'h0010_0000, 32'h0000_8000, 0);
		queue_sample(0, 32'h8000_0000);
		queue_sample(1, 32'h7FFF_FFFF);
		queue_lookup(32'h0001_0000, 1'b0);
		queue_lookup(32'h0001_8000, 1'b0);
		queue_lookup(32'h0000_0000, 1'b0);
		queue_lookup(32'hFFFF_FFFF, 1'b0);
		queue_lookup(32'h0010_0000, 1'b0);
		queue_lookup(32'h0000_FFFF, 1'b0);
		// unused function code and a descriptor index past the table
		plan_request(random_request(F_NONE));
		r = random_request(F_DESC);
		r.slot = '1;
		plan_request(r);
		// covered key but zero step
		queue_desc(0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 5);
		queue_lookup(32'h1234_5678, 1'b0);
		// index far past the store
		queue_desc(0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 0);
		queue_lookup(32'hFFFF_FFFF, 1'b0);
		queue_lookup(32'h0000_03FF, 1'b0);
		// base at the last address: index 0 hits, index 1 runs off the end
		queue_desc(0, 32'h0000_0100, 32'h0000_1000, 32'h0000_0010, STORE_DEPTH - 1);
		queue_lookup(32'h0000_0100, 1'b0);
		queue_lookup(32'h0000_0110, 1'b0);
		queue_sample(STORE_DEPTH - 1, 32'h0000_0000);
		queue_lookup(32'h0000_010F, 1'b1);
	endtask

	// Mostly lookups into a fresh table, with noise and broken descriptors
	task automatic queue_phase(int items);
		request_t r;
		int n, pick, i;
		desc_t d;
		n = (int'(seg_count) > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
		queue_table(n);
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 62 && n > 0) begin
				i = $urandom_range(0, n - 1);
				d = planned_segs[i];
				case ($urandom_range(0, 5))
					0: queue_lookup(d.lo, 1'b0);
					1: queue_lookup(d.hi, 1'b0);
					2: queue_lookup(d.lo - 1, 1'b0);
					3: queue_lookup(d.hi + 1, 1'b0);
					default: queue_lookup(d.lo + FIELD_W'($urandom_range(0, d.hi - d.lo)), 1'b0);
				endcase
			end else if (pick < 72) begin
				queue_lookup($urandom, 1'b0);
			end else if (pick < 82) begin
				plan_request(random_request(F_SAMPLE));
			end else if (pick < 87) begin
				plan_request(random_request(F_NONE));
			end else if (pick < 92) begin
				r = random_request(F_DESC);
				r.slot = SLOT_W'($urandom_range(MAX_SEGMENTS, 2 ** SLOT_W - 1));
				plan_request(r);
			end else if (pick < 96) begin
				r = random_request(F_DESC);
				r.slot = SLOT_W'($urandom_range(0, MAX_SEGMENTS - 1));
				plan_request(r);
			end else begin
				queue_table(n);
			end
		end
	endtask

	task automatic write_count(logic [CNT_W-1:0] c);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		seg_count = c;
		settings_written++;
	endtask

	// wait for all beats to drain, then let any write in flight finish
	task automatic settle();
		while (pending_requests.size() != 0 || in_valid || awaited_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			drive_next = in_valid;
			if (in_valid && !in_stall) begin
				apply_request(cur_req);
				beats_in++;
				drive_next = 1'b0;
				send_wait = draw_wait(send_calm);
			end
			if (!drive_next) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pending_requests.size() != 0 &&
						(!pending_requests[0].drain_first || awaited_lookups.size() == 0)) begin
					cur_req = pending_requests.pop_front();
					func <= cur_req.func;
					slot <= cur_req.slot;
					seg_start <= cur_req.seg_start;
					seg_end <= cur_req.seg_end;
					seg_step <= cur_req.seg_step;
					seg_base <= cur_req.seg_base;
					sample_value <= cur_req.sample_value;
					key <= cur_req.key;
					drive_next = 1'b1;
				end
			end
			in_valid <= drive_next;
		end
	end

	// result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_lookups.size() == 0) begin
					$error("result beat with no lookup pending: value %h found %b", value, found);
					fail_count++;
				end else begin
					result_want = awaited_lookups.pop_front();
					if (value !== result_want.value) begin
						$error("value mismatch: expected %h, got %h", result_want.value, value);
						fail_count++;
					end
					if (found !== result_want.found) begin
						$error("found mismatch: expected %b, got %b", result_want.found, found);
						fail_count++;
					end
					lookups_checked++;
					if (result_want.found)
						lookups_found++;
				end
				recv_wait = draw_wait(recv_calm);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_stall <= (recv_wait > 0);
		end
	end

	// watchdog: no beat on any port for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d lookups outstanding",
				idle_cycles, awaited_lookups.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// sequence: reset, directed beats at reset count, then one phase per setting
	initial begin
		logic [CNT_W-1:0] c;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		queue_directed();
		settle();
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: c = CNT_W'(0);
				1: c = CNT_W'(MAX_SEGMENTS);
				2: c = '1;
				3: c = CNT_W'(1);
				default: c = CNT_W'($urandom_range(1, 2 ** CNT_W - 1));
			endcase
			write_count(c);
			queue_phase((c == '0) ? 40 : 70);
			settle();
		end
		$display("Run covered %0d request beats and %0d checked lookups (%0d found, %0d missed)",
			beats_in, lookups_checked, lookups_found, lookups_checked - lookups_found);
		$display("over %0d segment_count settings, including 0, %0d and the 5-bit maximum",
			settings_written, MAX_SEGMENTS);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
